FILE: src/tcl_pkg.sv
`timescale 1ns / 1ps
// Package: shared constants, codes and widths of the tilt car light pixel shader.
package tcl_pkg;

    localparam int COORD_W      = 8;
    localparam int ACCEL_W      = 16;
    localparam int FRAME_W      = 4;
    localparam int COLOR_W      = 8;
    localparam int BRIGHT_W     = 7;
    localparam int APB_ADDR_W   = 5;
    localparam int APB_DATA_W   = 32;
    localparam int REG_IDX_W    = 3;

    localparam int BAND_ROWS    = 13;
    localparam int EDGE_COLS    = 3;
    localparam int BLINK_PERIOD = 10;
    localparam int BLINK_ON     = 5;
    localparam int AMBER_GREEN  = 147;
    localparam int FULL_PERCENT = 100;

    localparam int DIVISOR_W    = COORD_W;
    localparam int DIVIDEND_W   = 14;
    localparam int DIV_STEPS    = BRIGHT_W;
    localparam int DIV_CNT_W    = $clog2(DIV_STEPS);
    localparam int DIV_SHIFT    = DIV_STEPS - 1;

    localparam logic KIND_FRAME = 1'b0;
    localparam logic KIND_PIXEL = 1'b1;

    localparam logic [REG_IDX_W-1:0] REG_GRID_WIDTH  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_GRID_HEIGHT = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_FWD_THR     = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_BWD_THR     = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_LEFT_THR    = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_RIGHT_THR   = 3'd5;

    typedef enum logic [1:0] {
        TURN_LEFT     = 2'd0,
        TURN_STRAIGHT = 2'd1,
        TURN_RIGHT    = 2'd2
    } t_turn;

endpackage

FILE: src/tcl_if.sv
`timescale 1ns / 1ps
// Interfaces: pixel request channel and pixel color channel.
interface tcl_in_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 kind;
    logic signed [tcl_pkg::ACCEL_W-1:0]   accel_x;
    logic signed [tcl_pkg::ACCEL_W-1:0]   accel_y;
    logic        [tcl_pkg::COORD_W-1:0]   pixel_col;
    logic        [tcl_pkg::COORD_W-1:0]   pixel_row;
    logic        [tcl_pkg::FRAME_W-1:0]   frame_index;

    modport source (
        output valid, kind, accel_x, accel_y, pixel_col, pixel_row, frame_index,
        input  ready
    );
    modport sink (
        input  valid, kind, accel_x, accel_y, pixel_col, pixel_row, frame_index,
        output ready
    );
endinterface

interface tcl_out_if;
    logic                             valid;
    logic                             ready;
    logic [tcl_pkg::COLOR_W-1:0]      red;
    logic [tcl_pkg::COLOR_W-1:0]      green;
    logic [tcl_pkg::COLOR_W-1:0]      blue;
    logic [tcl_pkg::BRIGHT_W-1:0]     brightness;
    logic                             brightness_set;

    modport source (
        output valid, red, green, blue, brightness, brightness_set,
        input  ready
    );
    modport sink (
        input  valid, red, green, blue, brightness, brightness_set,
        output ready
    );
endinterface

FILE: src/tcl_div.sv
`timescale 1ns / 1ps
// Serial restoring divider: one quotient bit per cycle through a shared subtractor.
module tcl_div (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic [tcl_pkg::DIVIDEND_W-1:0]      i_dividend,
    input  logic [tcl_pkg::DIVISOR_W-1:0]       i_divisor,
    output logic                                o_done,
    output logic [tcl_pkg::BRIGHT_W-1:0]        o_quotient
);

    logic                               r_busy;
    logic                               r_done;
    logic [tcl_pkg::DIV_CNT_W-1:0]      r_cnt;
    logic [tcl_pkg::DIVIDEND_W-1:0]     r_rem;
    logic [tcl_pkg::DIVIDEND_W-1:0]     r_dsor;
    logic [tcl_pkg::BRIGHT_W-1:0]       r_quo;
    logic                               w_ge;

    assign w_ge       = (r_rem >= r_dsor);
    assign o_done     = r_done;
    assign o_quotient = r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == tcl_pkg::DIV_CNT_W'(tcl_pkg::DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= i_dividend;
            r_dsor <= {i_divisor, {tcl_pkg::DIV_SHIFT{1'b0}}};
            r_quo  <= '0;
        end else if (r_busy) begin
            if (w_ge) begin
                r_rem <= r_rem - r_dsor;
            end
            r_quo  <= {r_quo[tcl_pkg::BRIGHT_W-2:0], w_ge};
            r_dsor <= r_dsor >> 1;
        end
    end

endmodule

FILE: src/tilt_car_light_pixel_shader_core.sv
`timescale 1ns / 1ps
// Top level: tilt car light pixel shader core with APB register port.
// A frame-start transaction updates the direction and turn state in the cycle it is
// accepted and yields no result. A pixel in the head or tail band is shaded
// combinationally, and its color is loaded into the output register at acceptance.
// A middle-row pixel is taken, the prep state forms the scaled distance and starts
// the bit-serial divider (one quotient bit per cycle), the quotient is picked up,
// and the output register is loaded once it is free; the input is not ready during
// that time. The input is ready only when the output register is empty or being
// emptied in the same cycle.
module tilt_car_light_pixel_shader_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [tcl_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [tcl_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [tcl_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                pready,
    tcl_in_if.sink                              i_px,
    tcl_out_if.source                           o_px
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_PREP = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_DONE = 4'b1000
    } t_state;

    t_state                                 r_state;
    t_state                                 n_state;

    logic [tcl_pkg::COORD_W-1:0]            r_grid_width;
    logic [tcl_pkg::COORD_W-1:0]            r_grid_height;
    logic signed [tcl_pkg::ACCEL_W-1:0]     r_fwd_thr;
    logic signed [tcl_pkg::ACCEL_W-1:0]     r_bwd_thr;
    logic signed [tcl_pkg::ACCEL_W-1:0]     r_left_thr;
    logic signed [tcl_pkg::ACCEL_W-1:0]     r_right_thr;

    logic                                   r_fwd;
    tcl_pkg::t_turn                         r_turn;

    logic [tcl_pkg::COORD_W-1:0]            r_rows;
    logic [tcl_pkg::BRIGHT_W-1:0]           r_mag;
    logic                                   r_white;
    logic [tcl_pkg::BRIGHT_W-1:0]           r_bright;

    logic                                   r_out_valid;
    logic [tcl_pkg::COLOR_W-1:0]            r_out_red;
    logic [tcl_pkg::COLOR_W-1:0]            r_out_green;
    logic [tcl_pkg::COLOR_W-1:0]            r_out_blue;
    logic [tcl_pkg::BRIGHT_W-1:0]           r_out_bright;
    logic                                   r_out_bset;

    logic                                   w_cfg_wr;
    logic [tcl_pkg::REG_IDX_W-1:0]          w_reg_idx;
    logic                                   w_out_free;
    logic                                   w_accept;
    logic                                   w_frame_acc;
    logic                                   w_pixel_acc;
    logic [tcl_pkg::COORD_W:0]              w_row9;
    logic [tcl_pkg::COORD_W:0]              w_col9;
    logic                                   w_top_band;
    logic                                   w_band;
    logic                                   w_band_white;
    logic                                   w_edge;
    logic                                   w_blink_on;
    logic [tcl_pkg::COLOR_W-1:0]            w_band_red;
    logic [tcl_pkg::COLOR_W-1:0]            w_band_green;
    logic [tcl_pkg::COLOR_W-1:0]            w_band_blue;
    logic [tcl_pkg::COORD_W-1:0]            w_rows;
    logic [tcl_pkg::COORD_W-1:0]            w_z;
    logic signed [tcl_pkg::COORD_W:0]       w_p;
    logic [tcl_pkg::COORD_W:0]              w_mag9;
    logic                                   w_load_band;
    logic                                   w_load_mid;
    logic                                   w_div_start;
    logic [tcl_pkg::DIVIDEND_W-1:0]         w_dividend;
    logic                                   w_div_done;
    logic [tcl_pkg::BRIGHT_W-1:0]           w_quotient;

    assign pready    = 1'b1;
    assign w_cfg_wr  = psel && penable && pwrite && pready;
    assign w_reg_idx = paddr[tcl_pkg::APB_ADDR_W-1:2];

    always_comb begin
        prdata = '0;
        unique case (w_reg_idx)
            tcl_pkg::REG_GRID_WIDTH:  prdata = tcl_pkg::APB_DATA_W'(r_grid_width);
            tcl_pkg::REG_GRID_HEIGHT: prdata = tcl_pkg::APB_DATA_W'(r_grid_height);
            tcl_pkg::REG_FWD_THR:     prdata = tcl_pkg::APB_DATA_W'(r_fwd_thr);
            tcl_pkg::REG_BWD_THR:     prdata = tcl_pkg::APB_DATA_W'(r_bwd_thr);
            tcl_pkg::REG_LEFT_THR:    prdata = tcl_pkg::APB_DATA_W'(r_left_thr);
            tcl_pkg::REG_RIGHT_THR:   prdata = tcl_pkg::APB_DATA_W'(r_right_thr);
            default:                  prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width  <= tcl_pkg::COORD_W'(16);
            r_grid_height <= tcl_pkg::COORD_W'(60);
            r_fwd_thr     <= tcl_pkg::ACCEL_W'(6000);
            r_bwd_thr     <= -tcl_pkg::ACCEL_W'(6000);
            r_left_thr    <= tcl_pkg::ACCEL_W'(3000);
            r_right_thr   <= -tcl_pkg::ACCEL_W'(3000);
        end else if (w_cfg_wr) begin
            unique case (w_reg_idx)
                tcl_pkg::REG_GRID_WIDTH:  r_grid_width  <= pwdata[tcl_pkg::COORD_W-1:0];
                tcl_pkg::REG_GRID_HEIGHT: r_grid_height <= pwdata[tcl_pkg::COORD_W-1:0];
                tcl_pkg::REG_FWD_THR:     r_fwd_thr     <= pwdata[tcl_pkg::ACCEL_W-1:0];
                tcl_pkg::REG_BWD_THR:     r_bwd_thr     <= pwdata[tcl_pkg::ACCEL_W-1:0];
                tcl_pkg::REG_LEFT_THR:    r_left_thr    <= pwdata[tcl_pkg::ACCEL_W-1:0];
                tcl_pkg::REG_RIGHT_THR:   r_right_thr   <= pwdata[tcl_pkg::ACCEL_W-1:0];
                default: ;
            endcase
        end
    end

    assign w_out_free  = !r_out_valid || o_px.ready;
    assign i_px.ready  = (r_state == ST_IDLE) && w_out_free;
    assign w_accept    = i_px.valid && i_px.ready;
    assign w_frame_acc = w_accept && (i_px.kind == tcl_pkg::KIND_FRAME);
    assign w_pixel_acc = w_accept && (i_px.kind == tcl_pkg::KIND_PIXEL);

    // band and edge tests
    assign w_row9     = {1'b0, i_px.pixel_row};
    assign w_col9     = {1'b0, i_px.pixel_col};
    assign w_top_band = (i_px.pixel_row < tcl_pkg::COORD_W'(tcl_pkg::BAND_ROWS));
    assign w_band     = w_top_band
                     || ((w_row9 + (tcl_pkg::COORD_W+1)'(tcl_pkg::BAND_ROWS))
                         >= {1'b0, r_grid_height});
    assign w_band_white = w_top_band ? r_fwd : !r_fwd;
    assign w_edge = ((i_px.pixel_col < tcl_pkg::COORD_W'(tcl_pkg::EDGE_COLS))
                     && (r_turn == tcl_pkg::TURN_LEFT))
                 || (((w_col9 + (tcl_pkg::COORD_W+1)'(tcl_pkg::EDGE_COLS + 1))
                      > {1'b0, r_grid_width})
                     && (r_turn == tcl_pkg::TURN_RIGHT));
    assign w_blink_on = (i_px.frame_index < tcl_pkg::FRAME_W'(tcl_pkg::BLINK_ON))
                     || ((i_px.frame_index >= tcl_pkg::FRAME_W'(tcl_pkg::BLINK_PERIOD))
                         && (i_px.frame_index
                             < tcl_pkg::FRAME_W'(tcl_pkg::BLINK_PERIOD + tcl_pkg::BLINK_ON)));

    always_comb begin
        if (w_edge) begin
            w_band_red   = w_blink_on ? '1 : '0;
            w_band_green = w_blink_on ? tcl_pkg::COLOR_W'(tcl_pkg::AMBER_GREEN) : '0;
            w_band_blue  = '0;
        end else begin
            w_band_red   = '1;
            w_band_green = w_band_white ? '1 : '0;
            w_band_blue  = w_band_white ? '1 : '0;
        end
    end

    // middle-row distance from the split row
    assign w_rows = r_grid_height - tcl_pkg::COORD_W'(2 * tcl_pkg::BAND_ROWS);
    assign w_z    = i_px.pixel_row - tcl_pkg::COORD_W'(tcl_pkg::BAND_ROWS);
    assign w_p    = $signed({2'b00, w_rows[tcl_pkg::COORD_W-1:1]}) - $signed({1'b0, w_z});
    assign w_mag9 = w_p[tcl_pkg::COORD_W] ? 9'(-w_p) : 9'(w_p);

    assign w_load_band = w_pixel_acc && w_band;
    assign w_load_mid  = (r_state == ST_DONE) && w_out_free;
    assign w_div_start = (r_state == ST_PREP);
    assign w_dividend  = tcl_pkg::DIVIDEND_W'(r_mag) * tcl_pkg::DIVIDEND_W'(tcl_pkg::FULL_PERCENT);

    tcl_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dividend),
        .i_divisor  (r_rows),
        .o_done     (w_div_done),
        .o_quotient (w_quotient)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (w_pixel_acc && !w_band) n_state = ST_PREP;
            ST_PREP: n_state = ST_DIV;
            ST_DIV:  if (w_div_done) n_state = ST_DONE;
            ST_DONE: if (w_out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_fwd       <= 1'b1;
            r_turn      <= tcl_pkg::TURN_STRAIGHT;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_frame_acc) begin
                if (i_px.accel_y > r_fwd_thr) begin
                    r_fwd <= 1'b1;
                end else if (i_px.accel_y < r_bwd_thr) begin
                    r_fwd <= 1'b0;
                end
                if (i_px.accel_x < r_right_thr) begin
                    r_turn <= tcl_pkg::TURN_RIGHT;
                end else if (i_px.accel_x > r_left_thr) begin
                    r_turn <= tcl_pkg::TURN_LEFT;
                end else begin
                    r_turn <= tcl_pkg::TURN_STRAIGHT;
                end
            end
            if (w_load_band || w_load_mid) begin
                r_out_valid <= 1'b1;
            end else if (o_px.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pixel_acc && !w_band) begin
            r_rows  <= w_rows;
            r_mag   <= w_mag9[tcl_pkg::BRIGHT_W-1:0];
            r_white <= (r_fwd == !w_p[tcl_pkg::COORD_W]);
        end
        if (w_div_done) begin
            r_bright <= w_quotient;
        end
        if (w_load_band) begin
            r_out_red    <= w_band_red;
            r_out_green  <= w_band_green;
            r_out_blue   <= w_band_blue;
            r_out_bright <= '0;
            r_out_bset   <= 1'b0;
        end else if (w_load_mid) begin
            r_out_red    <= '1;
            r_out_green  <= r_white ? '1 : '0;
            r_out_blue   <= r_white ? '1 : '0;
            r_out_bright <= r_bright;
            r_out_bset   <= 1'b1;
        end
    end

    assign o_px.valid          = r_out_valid;
    assign o_px.red            = r_out_red;
    assign o_px.green          = r_out_green;
    assign o_px.blue           = r_out_blue;
    assign o_px.brightness     = r_out_bright;
    assign o_px.brightness_set = r_out_bset;

`ifndef SYNTHESIS
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_px.ready |-> (r_state == ST_IDLE))
        else $error("input ready outside idle");
    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == ST_DIV))
        else $error("divider finished outside divide state");
    a_prep_to_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_PREP) |=> (r_state == ST_DIV))
        else $error("prep did not advance to divide");
    a_mid_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_bset)
            |-> (r_out_bright <= tcl_pkg::BRIGHT_W'(tcl_pkg::FULL_PERCENT)))
        else $error("brightness above full scale");
    a_band_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_bset) |-> (r_out_bright == '0))
        else $error("band pixel with nonzero brightness");
`endif

endmodule

FILE: dv/tilt_car_light_pixel_shader_core_tb.sv
`timescale 1ns / 1ps
// Testbench: tilt car light pixel shader core checked against a color predictor.
module tilt_car_light_pixel_shader_core_tb;
    import tcl_pkg::*;

    localparam int RESET_CYCLES  = 6;
    localparam int SETTLE_CYCLES = 16;
    localparam int IDLE_LIMIT    = 2000;
    localparam int HOLD_CYCLES   = 300;
    localparam int HOLD_ITEMS    = 24;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS   = 250;

    localparam logic [REG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    typedef struct packed {
        logic                       kind;
        logic signed [ACCEL_W-1:0]  accel_x;
        logic signed [ACCEL_W-1:0]  accel_y;
        logic [COORD_W-1:0]         pixel_col;
        logic [COORD_W-1:0]         pixel_row;
        logic [FRAME_W-1:0]         frame_index;
    } shade_req_t;

    typedef struct packed {
        logic [COLOR_W-1:0]  red;
        logic [COLOR_W-1:0]  green;
        logic [COLOR_W-1:0]  blue;
        logic [BRIGHT_W-1:0] brightness;
        logic                brightness_set;
    } shade_color_t;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    tcl_in_if  px_in ();
    tcl_out_if px_out ();

    tilt_car_light_pixel_shader_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_px    (px_in),
        .o_px    (px_out)
    );

    logic [COORD_W-1:0]        grid_w    = 8'd16;
    logic [COORD_W-1:0]        grid_h    = 8'd60;
    logic signed [ACCEL_W-1:0] fwd_thr   = 16'sd6000;
    logic signed [ACCEL_W-1:0] bwd_thr   = -16'sd6000;
    logic signed [ACCEL_W-1:0] left_thr  = 16'sd3000;
    logic signed [ACCEL_W-1:0] right_thr = -16'sd3000;
    bit                        going_fwd = 1'b1;
    t_turn                     turn      = TURN_STRAIGHT;

    shade_color_t pending_colors[$];
    int           err_cnt    = 0;
    int           n_frames   = 0;
    int           n_pixels   = 0;
    int           n_checked  = 0;
    int           n_writes   = 0;
    int           idle_cycles = 0;
    bit           gaps_on    = 1'b1;
    int           hold_req   = 0;

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    function automatic bit shade_request(input shade_req_t rq, output shade_color_t c);
        int col;
        int row;
        int h;
        int w;
        int rows;
        int p;
        int mag;
        bit white;
        c = '0;
        if (rq.kind == KIND_FRAME) begin
            if (rq.accel_y > fwd_thr) begin
                going_fwd = 1'b1;
            end else if (rq.accel_y < bwd_thr) begin
                going_fwd = 1'b0;
            end
            if (rq.accel_x < right_thr) begin
                turn = TURN_RIGHT;
            end else if (rq.accel_x > left_thr) begin
                turn = TURN_LEFT;
            end else begin
                turn = TURN_STRAIGHT;
            end
            return 1'b0;
        end
        col = int'(rq.pixel_col);
        row = int'(rq.pixel_row);
        h   = int'(grid_h);
        w   = int'(grid_w);
        if (row < BAND_ROWS || row >= h - BAND_ROWS) begin
            white   = (row < BAND_ROWS) ? going_fwd : !going_fwd;
            c.red   = 8'd255;
            c.green = white ? 8'd255 : 8'd0;
            c.blue  = white ? 8'd255 : 8'd0;
            if ((col < EDGE_COLS && turn == TURN_LEFT) ||
                (col > (w - 1) - EDGE_COLS && turn == TURN_RIGHT)) begin
                if (int'(rq.frame_index) % BLINK_PERIOD < BLINK_ON) begin
                    c.red   = 8'd255;
                    c.green = COLOR_W'(AMBER_GREEN);
                    c.blue  = 8'd0;
                end else begin
                    c.red   = 8'd0;
                    c.green = 8'd0;
                    c.blue  = 8'd0;
                end
            end
            return 1'b1;
        end
        rows  = h - 2 * BAND_ROWS;
        p     = rows / 2 - (row - BAND_ROWS);
        mag   = (p < 0) ? -p : p;
        white = (going_fwd && p >= 0) || (!going_fwd && p < 0);
        c.red            = 8'd255;
        c.green          = white ? 8'd255 : 8'd0;
        c.blue           = white ? 8'd255 : 8'd0;
        c.brightness     = BRIGHT_W'((mag * FULL_PERCENT) / rows);
        c.brightness_set = 1'b1;
        return 1'b1;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            err_cnt++;
        end
    endtask

    always @(posedge i_clk) begin
        shade_req_t   rq;
        shade_color_t got;
        shade_color_t want;
        shade_color_t predicted;
        if (i_rst_n) begin
            if (px_out.valid && px_out.ready) begin
                got = '{px_out.red, px_out.green, px_out.blue, px_out.brightness,
                        px_out.brightness_set};
                if (pending_colors.size() == 0) begin
                    $error("color transaction with no request waiting");
                    err_cnt++;
                end else begin
                    want = pending_colors.pop_front();
                    check_field("red", want.red, got.red);
                    check_field("green", want.green, got.green);
                    check_field("blue", want.blue, got.blue);
                    check_field("brightness", want.brightness, got.brightness);
                    check_field("brightness_set", want.brightness_set, got.brightness_set);
                    n_checked++;
                end
            end
            if (px_in.valid && px_in.ready) begin
                rq = '{px_in.kind, px_in.accel_x, px_in.accel_y, px_in.pixel_col,
                       px_in.pixel_row, px_in.frame_index};
                if (shade_request(rq, predicted)) begin
                    pending_colors.push_back(predicted);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (px_in.valid && px_in.ready) || (px_out.valid && px_out.ready) ||
            psel) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $error("no transaction for %0d cycles", IDLE_LIMIT);
                $display("status: fail");
                $finish;
            end
        end
    end

    function automatic int rand_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!gaps_on || r < 60) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    initial begin
        int stall_left;
        stall_left   = 0;
        px_out.ready = 1'b0;
        wait (i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_req > 0) begin
                px_out.ready = 1'b0;
                repeat (hold_req - 1) @(negedge i_clk);
                hold_req = 0;
            end else if (stall_left > 0) begin
                px_out.ready = 1'b0;
                stall_left--;
            end else begin
                px_out.ready = 1'b1;
                stall_left   = rand_gap();
            end
        end
    end

    task automatic reg_write(input logic [REG_IDX_W-1:0] idx, input logic [31:0] val);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = val;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        case (idx)
            REG_GRID_WIDTH:  grid_w    = val[COORD_W-1:0];
            REG_GRID_HEIGHT: grid_h    = val[COORD_W-1:0];
            REG_FWD_THR:     fwd_thr   = val[ACCEL_W-1:0];
            REG_BWD_THR:     bwd_thr   = val[ACCEL_W-1:0];
            REG_LEFT_THR:    left_thr  = val[ACCEL_W-1:0];
            REG_RIGHT_THR:   right_thr = val[ACCEL_W-1:0];
            default: ;
        endcase
        n_writes++;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic reg_read_check(input logic [REG_IDX_W-1:0] idx);
        logic [ACCEL_W-1:0] want;
        logic [ACCEL_W-1:0] got;
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = {idx, 2'b00};
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        got = prdata[ACCEL_W-1:0];
        case (idx)
            REG_GRID_WIDTH: begin
                want = {8'd0, grid_w};
                got  = {8'd0, prdata[COORD_W-1:0]};
            end
            REG_GRID_HEIGHT: begin
                want = {8'd0, grid_h};
                got  = {8'd0, prdata[COORD_W-1:0]};
            end
            REG_FWD_THR:   want = fwd_thr;
            REG_BWD_THR:   want = bwd_thr;
            REG_LEFT_THR:  want = left_thr;
            REG_RIGHT_THR: want = right_thr;
            default:       want = got;
        endcase
        check_field($sformatf("register %0d", idx), want, got);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    task automatic read_all_regs();
        for (int i = REG_GRID_WIDTH; i <= REG_RIGHT_THR; i++) begin
            reg_read_check(REG_IDX_W'(i));
        end
    endtask

    task automatic send(input shade_req_t rq);
        int gap;
        @(negedge i_clk);
        px_in.valid       = 1'b1;
        px_in.kind        = rq.kind;
        px_in.accel_x     = rq.accel_x;
        px_in.accel_y     = rq.accel_y;
        px_in.pixel_col   = rq.pixel_col;
        px_in.pixel_row   = rq.pixel_row;
        px_in.frame_index = rq.frame_index;
        @(posedge i_clk);
        while (!px_in.ready) @(posedge i_clk);
        if (rq.kind == KIND_FRAME) begin
            n_frames++;
        end else begin
            n_pixels++;
        end
        gap = rand_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            px_in.valid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        px_in.valid = 1'b0;
        while (pending_colors.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic shade_req_t frame_item(input logic signed [ACCEL_W-1:0] ax,
                                              input logic signed [ACCEL_W-1:0] ay);
        shade_req_t rq;
        rq             = '0;
        rq.kind        = KIND_FRAME;
        rq.accel_x     = ax;
        rq.accel_y     = ay;
        rq.pixel_col   = COORD_W'($urandom);
        rq.pixel_row   = COORD_W'($urandom);
        rq.frame_index = FRAME_W'($urandom);
        return rq;
    endfunction

    function automatic shade_req_t pixel_item(input int col, input int row, input int frame);
        shade_req_t rq;
        rq             = '0;
        rq.kind        = KIND_PIXEL;
        rq.accel_x     = ACCEL_W'($urandom);
        rq.accel_y     = ACCEL_W'($urandom);
        rq.pixel_col   = COORD_W'(col);
        rq.pixel_row   = COORD_W'(row);
        rq.frame_index = FRAME_W'(frame);
        return rq;
    endfunction

    function automatic logic signed [ACCEL_W-1:0] rand_accel();
        int r;
        logic signed [ACCEL_W-1:0] base;
        r = $urandom_range(0, 9);
        case (r % 4)
            0:       base = fwd_thr;
            1:       base = bwd_thr;
            2:       base = left_thr;
            default: base = right_thr;
        endcase
        if (r < 4) begin
            return ACCEL_W'($urandom);
        end
        return base + ACCEL_W'($urandom_range(0, 6)) - 16'sd3;
    endfunction

    function automatic shade_req_t rand_request();
        shade_req_t rq;
        rq = pixel_item(0, 0, 0);
        if ($urandom_range(0, 99) < 15) begin
            rq.kind = KIND_FRAME;
        end
        rq.accel_x = rand_accel();
        rq.accel_y = rand_accel();
        if ($urandom_range(0, 99) < 85) begin
            rq.pixel_row = COORD_W'($urandom_range(0, int'(grid_h) - 1));
            rq.pixel_col = COORD_W'($urandom_range(0, int'(grid_w) - 1));
        end else begin
            rq.pixel_row = COORD_W'($urandom);
            rq.pixel_col = COORD_W'($urandom);
        end
        if ($urandom_range(0, 99) < 80) begin
            rq.frame_index = FRAME_W'($urandom_range(0, BLINK_PERIOD - 1));
        end else begin
            rq.frame_index = FRAME_W'($urandom_range(BLINK_PERIOD, 15));
        end
        return rq;
    endfunction

    function automatic int pick_size(input int lo, input int hi, input int typ);
        int r;
        r = $urandom_range(0, 9);
        if (r < 2) begin
            return lo;
        end
        if (r < 4) begin
            return hi;
        end
        return $urandom_range(lo, typ);
    endfunction

    function automatic logic [31:0] rand_threshold();
        int r;
        logic signed [ACCEL_W-1:0] t;
        r = $urandom_range(0, 9);
        if (r == 0) begin
            t = 16'sh7fff;
        end else if (r == 1) begin
            t = 16'sh8000;
        end else if (r < 5) begin
            t = ACCEL_W'($urandom);
        end else begin
            t = ACCEL_W'($urandom_range(0, 16000)) - 16'sd8000;
        end
        return {{16{t[ACCEL_W-1]}}, t};
    endfunction

    task automatic test_reset_values();
        read_all_regs();
        send(pixel_item(0, 0, 0));
        send(pixel_item(15, 59, 0));
        send(pixel_item(7, 12, 3));
        send(pixel_item(7, 13, 3));
        send(pixel_item(7, 29, 3));
        send(pixel_item(7, 30, 3));
        send(pixel_item(7, 46, 3));
        send(pixel_item(7, 47, 3));
    endtask

    task automatic test_tilt_and_turn();
        send(frame_item(16'sd0, 16'sd0));
        send(frame_item(16'sh7fff, 16'sh8000));
        send(pixel_item(0, 0, 4));
        send(pixel_item(2, 12, 5));
        send(pixel_item(3, 0, 0));
        send(pixel_item(255, 255, 15));
        send(pixel_item(5, 30, 0));
        send(frame_item(16'sh8000, 16'sh7fff));
        send(pixel_item(13, 50, 14));
        send(pixel_item(15, 5, 9));
        send(pixel_item(12, 59, 0));
        send(pixel_item(255, 0, 10));
        send(frame_item(16'sd3000, 16'sd6000));
        send(pixel_item(0, 0, 0));
        send(frame_item(-16'sd3001, -16'sd6001));
        send(pixel_item(13, 20, 3));
        send(frame_item(16'sd3001, 16'sd6001));
        send(pixel_item(1, 58, 7));
        send(frame_item(-16'sd3000, -16'sd6000));
        send(pixel_item(0, 58, 2));
    endtask

    task automatic test_register_settings();
        wait_drained();
        reg_write(REG_GRID_WIDTH, 32'd2);
        reg_write(REG_GRID_HEIGHT, 32'd20);
        read_all_regs();
        send(pixel_item(0, 13, 0));
        send(frame_item(16'sh8000, 16'sd0));
        send(pixel_item(0, 10, 2));
        send(pixel_item(1, 19, 8));
        wait_drained();
        reg_write(REG_GRID_WIDTH, 32'd3);
        reg_write(REG_GRID_HEIGHT, 32'd27);
        send(pixel_item(0, 13, 1));
        send(pixel_item(2, 14, 0));
        wait_drained();
        reg_write(REG_GRID_HEIGHT, 32'd26);
        send(pixel_item(0, 13, 0));
        wait_drained();
        reg_write(REG_GRID_WIDTH, 32'd255);
        reg_write(REG_GRID_HEIGHT, 32'd255);
        reg_write(REG_FWD_THR, 32'h0000_7fff);
        reg_write(REG_BWD_THR, 32'hffff_8000);
        reg_write(REG_LEFT_THR, 32'hffff_ff9c);
        reg_write(REG_RIGHT_THR, 32'd100);
        reg_write(REG_SPARE_LO, 32'hffff_ffff);
        reg_write(REG_SPARE_HI, 32'h0000_5a5a);
        read_all_regs();
        send(frame_item(16'sd0, 16'sh7fff));
        send(pixel_item(254, 0, 0));
        send(pixel_item(255, 127, 3));
        send(pixel_item(0, 241, 6));
        send(frame_item(16'sd200, 16'sh8000));
        send(pixel_item(2, 250, 1));
        wait_drained();
        reg_write(REG_LEFT_THR, 32'h0000_7fff);
        reg_write(REG_RIGHT_THR, 32'hffff_8000);
        reg_write(REG_FWD_THR, 32'hffff_8000);
        read_all_regs();
        send(frame_item(16'sh7fff, 16'sh8000));
        send(pixel_item(0, 12, 0));
        send(pixel_item(128, 100, 4));
    endtask

    task automatic test_random_traffic();
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            wait_drained();
            reg_write(REG_GRID_WIDTH, 32'(pick_size(4, 255, 40)));
            reg_write(REG_GRID_HEIGHT, 32'(pick_size(27, 255, 80)));
            reg_write(REG_FWD_THR, rand_threshold());
            reg_write(REG_BWD_THR, rand_threshold());
            reg_write(REG_LEFT_THR, rand_threshold());
            reg_write(REG_RIGHT_THR, rand_threshold());
            gaps_on = (ph % 3) != 2;
            repeat (PHASE_ITEMS) send(rand_request());
        end
    endtask

    task automatic test_output_stall();
        wait_drained();
        gaps_on  = 1'b0;
        hold_req = HOLD_CYCLES;
        for (int i = 0; i < HOLD_ITEMS; i++) begin
            if (i % 6 == 5) begin
                send(frame_item(rand_accel(), rand_accel()));
            end else if (i % 2 == 0) begin
                send(pixel_item(i, 0, i));
            end else begin
                send(pixel_item(i, int'(grid_h) / 2, i));
            end
        end
        wait_drained();
        gaps_on = 1'b1;
    endtask

    initial begin
        i_rst_n           = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        px_in.valid       = 1'b0;
        px_in.kind        = KIND_FRAME;
        px_in.accel_x     = '0;
        px_in.accel_y     = '0;
        px_in.pixel_col   = '0;
        px_in.pixel_row   = '0;
        px_in.frame_index = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_values();
        test_tilt_and_turn();
        test_register_settings();
        test_output_stall();
        test_random_traffic();
        test_output_stall();
        wait_drained();

        if (pending_colors.size() != 0) begin
            $error("%0d expected colors never arrived", pending_colors.size());
            err_cnt++;
        end
        $display("covered %0d frame starts and %0d pixel requests, %0d colors compared",
                 n_frames, n_pixels, n_checked);
        $display("over %0d register writes incl. tiny grids and swapped thresholds, %0d-cycle stalls",
                 n_writes, HOLD_CYCLES);
        if (err_cnt == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
